/* sv/k_nearest_unique_keeper_core_assert.svh */
// ============================================================================
// k_nearest_unique_keeper_core_assert.svh
// Assertion macros shared by the k-best keeper RTL modules.
// ============================================================================
`ifndef K_NEAREST_UNIQUE_KEEPER_CORE_ASSERT_SVH
`define K_NEAREST_UNIQUE_KEEPER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define KNUK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KNUK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KNUK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define KNUK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* sv/knuk_pkg.sv */
// ============================================================================
// knuk_pkg
// Shared widths, codes and controller/datapath interface types of the
// k-best keeper.
// ============================================================================
package knuk_pkg;

    // default table depth
    localparam int SLOTS_DEF = 8;

    // field widths
    localparam int OP_W       = 2;
    localparam int EDGE_W     = 16;
    localparam int SEG_W      = 20;
    localparam int DIST_W     = 24;
    localparam int RSLOT_W    = 3;
    localparam int ACT_W      = 3;
    localparam int SLOT_OUT_W = 3;
    localparam int FILL_W     = 4;

    // stream word widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = ACT_W + 1;
    localparam int M_PAD_W   = M_TDATA_W - (SLOT_OUT_W + EDGE_W + SEG_W + DIST_W + FILL_W);

    // operations
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_OFFER = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // result actions
    localparam logic [ACT_W-1:0] ACT_CLEARED  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_IMPROVED = 3'd1;
    localparam logic [ACT_W-1:0] ACT_KEPT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_APPENDED = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REPLACED = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DROPPED  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd6;

    // table port address select
    localparam logic [2:0] SEL_MATCH = 3'd0;
    localparam logic [2:0] SEL_RSLOT = 3'd1;
    localparam logic [2:0] SEL_COUNT = 3'd2;
    localparam logic [2:0] SEL_SCAN  = 3'd3;
    localparam logic [2:0] SEL_WORST = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic             capture;
        logic             clear;
        logic             append;
        logic             write;
        logic             scan_init;
        logic             scan_step;
        logic             load;
        logic             show;
        logic [2:0]       sel;
        logic [ACT_W-1:0] action;
    } knuk_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;
        logic            improve;
        logic            room;
        logic            rslot_ok;
        logic            scan_last;
        logic            better;
        logic            out_free;
    } knuk_stat_t;

endpackage

/* sv/k_nearest_unique_keeper_core.sv */
// ============================================================================
// k_nearest_unique_keeper_core
// Bounded table of the SLOTS best entries with one entry per edge key:
// clear, offer and read-slot operations, one result word per operation.
// ============================================================================
//
// Channel  Dir  Ports                       Content
// s_       in   s_tvalid/s_tready/s_tdata   tuser: operation; tdata: key, segment,
//                s_tuser                      distance, read slot
// m_       out  m_tvalid/m_tready/m_tdata   tuser: action, entry valid; tdata: slot,
//                m_tuser                      entry fields, fill count
//
// Clear, read and offers that hit a held key or append finish in the eval state.
// An offer of a new key to a full table goes on to the scan and decide states: the
// worst entry is found by a scan over the single table read port, one slot per cycle.
// Reset clears the entry count, controller and result valid; table contents are
// undefined until written. A new word is taken while the last result waits;
// the controller holds its final step until the result register is free.
module k_nearest_unique_keeper_core #(
    parameter int SLOTS = knuk_pkg::SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] edge_key, [35:16] segment_id, [59:36] offered_distance,
    // [62:60] read_slot, [63] zero
    input  logic [knuk_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [knuk_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] slot_used, [18:3] entry_edge, [38:19] entry_segment,
    // [62:39] entry_distance, [66:63] fill_count, [71:67] zero
    output logic [knuk_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] action, [3] entry_valid
    output logic [knuk_pkg::M_TUSER_W-1:0] m_tuser
);
    import knuk_pkg::*;

    knuk_cmd_t  cmd;
    knuk_stat_t stat;

    // sequencer
    knuk_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table and result datapath
    knuk_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* sv/knuk_ctrl.sv */
// ============================================================================
// knuk_ctrl
// Sequencer of the k-best keeper: evaluates one word, runs the worst-entry
// scan when a new key is offered to a full table, and issues table and result commands.
// ============================================================================
`include "k_nearest_unique_keeper_core_assert.svh"

module knuk_ctrl #(
    parameter int SLOTS = knuk_pkg::SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  knuk_pkg::knuk_stat_t stat,
    output knuk_pkg::knuk_cmd_t  cmd
);
    import knuk_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb begin
        cmd        = '0;
        cmd.sel    = SEL_MATCH;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                unique case (stat.op)
                    OP_CLEAR: begin
                        cmd.action = ACT_CLEARED;
                        if (stat.out_free) begin
                            cmd.clear  = 1'b1;
                            cmd.load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    OP_READ: begin
                        cmd.sel    = SEL_RSLOT;
                        cmd.action = ACT_READ;
                        cmd.show   = stat.rslot_ok;
                        if (stat.out_free) begin
                            cmd.load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    OP_OFFER: begin
                        if (stat.hit) begin
                            cmd.sel    = SEL_MATCH;
                            cmd.show   = 1'b1;
                            cmd.action = stat.improve ? ACT_IMPROVED : ACT_KEPT;
                            if (stat.out_free) begin
                                cmd.write  = stat.improve;
                                cmd.load   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end else if (stat.room) begin
                            cmd.sel    = SEL_COUNT;
                            cmd.show   = 1'b1;
                            cmd.action = ACT_APPENDED;
                            if (stat.out_free) begin
                                cmd.write  = 1'b1;
                                cmd.append = 1'b1;
                                cmd.load   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end else begin
                            cmd.scan_init = 1'b1;
                            state_next    = (SLOTS == 1) ? ST_DECIDE : ST_SCAN;
                        end
                    end
                    default: begin
                        // unused operation: no result
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.sel       = SEL_SCAN;
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.sel    = SEL_WORST;
                cmd.show   = 1'b1;
                cmd.action = stat.better ? ACT_REPLACED : ACT_DROPPED;
                if (stat.out_free) begin
                    cmd.write  = stat.better;
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `KNUK_ASSERT_NEXT(a_capture_eval, aclk, aresetn, cmd.capture, state_reg == ST_EVAL, "captured word not evaluated")
    `KNUK_ASSERT_IMP(a_write_state, aclk, aresetn, cmd.write, (state_reg == ST_EVAL) || (state_reg == ST_DECIDE), "table write outside eval or decide")
    `KNUK_ASSERT_NEXT(a_scan_exit, aclk, aresetn, state_reg == ST_SCAN, (state_reg == ST_SCAN) || (state_reg == ST_DECIDE), "scan left to wrong state")

endmodule

/* sv/knuk_dpath.sv */
// ============================================================================
// knuk_dpath
// Datapath of the k-best keeper: captured word, entry table, key match,
// worst-entry scan registers and the result register.
// ============================================================================
`include "k_nearest_unique_keeper_core_assert.svh"

module knuk_dpath #(
    parameter int SLOTS = knuk_pkg::SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  knuk_pkg::knuk_cmd_t            cmd,
    output knuk_pkg::knuk_stat_t           stat,
    input  logic [knuk_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [knuk_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [knuk_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [knuk_pkg::M_TUSER_W-1:0] m_tuser
);
    import knuk_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = 6;

    // captured word
    logic [OP_W-1:0]    op_reg;
    logic [EDGE_W-1:0]  key_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [RSLOT_W-1:0] rslot_reg;

    // entry table
    logic [EDGE_W-1:0] edges_reg [SLOTS];
    logic [SEG_W-1:0]  segs_reg  [SLOTS];
    logic [DIST_W-1:0] dists_reg [SLOTS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // worst-entry scan
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  worst_idx_reg;
    logic [EDGE_W-1:0] worst_key_reg;
    logic [DIST_W-1:0] worst_dist_reg;

    // result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic [M_TUSER_W-1:0] m_tuser_next;

    logic                  hit;
    logic [IDX_W-1:0]      match_idx;
    logic [IDX_W-1:0]      addr;
    logic [EDGE_W-1:0]     rd_key;
    logic [SEG_W-1:0]      rd_seg;
    logic [DIST_W-1:0]     rd_dist;
    logic                  worse;
    logic [SLOT_OUT_W-1:0] res_slot;
    logic [EDGE_W-1:0]     res_key;
    logic [SEG_W-1:0]      res_seg;
    logic [DIST_W-1:0]     res_dist;

    // word capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_tuser[OP_W-1:0];
            key_reg   <= s_tdata[EDGE_W-1:0];
            seg_reg   <= s_tdata[EDGE_W +: SEG_W];
            dist_reg  <= s_tdata[EDGE_W+SEG_W +: DIST_W];
            rslot_reg <= s_tdata[EDGE_W+SEG_W+DIST_W +: RSLOT_W];
        end
    end

    // parallel key match over held entries
    always_comb begin
        hit       = 1'b0;
        match_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!hit && (CNT_W'(i) < count_reg) && (edges_reg[i] == key_reg)) begin
                hit       = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

    // table port address
    always_comb begin
        unique case (cmd.sel)
            SEL_MATCH: addr = match_idx;
            SEL_RSLOT: addr = IDX_W'(rslot_reg);
            SEL_COUNT: addr = IDX_W'(count_reg);
            SEL_SCAN:  addr = scan_idx_reg;
            SEL_WORST: addr = worst_idx_reg;
            default:   addr = '0;
        endcase
    end

    assign rd_key  = edges_reg[addr];
    assign rd_seg  = segs_reg[addr];
    assign rd_dist = dists_reg[addr];

    // status to controller
    always_comb begin
        stat.op        = op_reg;
        stat.hit       = hit;
        stat.improve   = dist_reg < rd_dist;
        stat.room      = count_reg < CNT_W'(SLOTS);
        stat.rslot_ok  = (CMP_W'(rslot_reg) < CMP_W'(SLOTS))
                      && (CMP_W'(rslot_reg) < CMP_W'(count_reg));
        stat.scan_last = scan_idx_reg == IDX_W'(SLOTS - 1);
        stat.better    = (dist_reg < worst_dist_reg)
                      || ((dist_reg == worst_dist_reg) && (key_reg < worst_key_reg));
        stat.out_free  = !m_tvalid_reg || m_tready;
    end

    // table write
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            edges_reg[addr] <= key_reg;
            segs_reg[addr]  <= seg_reg;
            dists_reg[addr] <= dist_reg;
        end
    end

    // entry count
    always_comb begin
        priority if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.append) begin
            count_next = count_reg + 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // worst-entry scan: largest distance, then larger key
    assign worse = (rd_dist > worst_dist_reg)
                || ((rd_dist == worst_dist_reg) && (rd_key > worst_key_reg));

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            worst_idx_reg  <= '0;
            worst_key_reg  <= edges_reg[0];
            worst_dist_reg <= dists_reg[0];
            scan_idx_reg   <= IDX_W'(1);
        end else if (cmd.scan_step) begin
            if (worse) begin
                worst_idx_reg  <= scan_idx_reg;
                worst_key_reg  <= rd_key;
                worst_dist_reg <= rd_dist;
            end
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
    end

    // result word; written entries show the new contents
    always_comb begin
        if (cmd.action == ACT_CLEARED) begin
            res_slot = '0;
        end else if (cmd.sel == SEL_RSLOT) begin
            res_slot = SLOT_OUT_W'(rslot_reg);
        end else begin
            res_slot = SLOT_OUT_W'(addr);
        end
        res_key  = cmd.show ? (cmd.write ? key_reg  : rd_key)  : '0;
        res_seg  = cmd.show ? (cmd.write ? seg_reg  : rd_seg)  : '0;
        res_dist = cmd.show ? (cmd.write ? dist_reg : rd_dist) : '0;
        m_tdata_next = {{M_PAD_W{1'b0}}, FILL_W'(count_next), res_dist, res_seg,
                        res_key, res_slot};
        m_tuser_next = {cmd.show, cmd.action};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `KNUK_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(SLOTS), "entry count above table depth")
    `KNUK_ASSERT_IMP(a_load_free, aclk, aresetn, cmd.load, !m_tvalid_reg || m_tready, "result overwritten before taken")
    `KNUK_ASSERT_NEXT(a_append_count, aclk, aresetn, cmd.append, count_reg == $past(count_reg) + 1'b1, "append did not grow count")

endmodule

/* test/k_nearest_unique_keeper_core_tb.sv */
// ----------------------------------------------------------------------------
// k_nearest_unique_keeper_core_tb
// Self-checking bench for the k-best keeper. Directed words cover clear,
// reads on an empty and a full table, ignored operations, key hits
// that improve or keep an entry, appends, and full-table offers that replace
// or drop around distance ties. Random runs then stream offer sequences over
// small key pools with random content. A table model predicts every result
// word, and each one is compared in order with what the core returns.
// ----------------------------------------------------------------------------
module k_nearest_unique_keeper_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import knuk_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;
    localparam int POOL_MAX = 16;

    // one result word, split into its fields
    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic                  valid;
        logic [SLOT_OUT_W-1:0] slot;
        logic [EDGE_W-1:0]     entry_key;
        logic [SEG_W-1:0]      entry_seg;
        logic [DIST_W-1:0]     entry_dist;
        logic [FILL_W-1:0]     fill;
        logic [M_PAD_W-1:0]    pad;
    } keeper_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // table model
    logic [EDGE_W-1:0] held_key [SLOTS];
    logic [SEG_W-1:0]  held_seg [SLOTS];
    logic [DIST_W-1:0] held_dist [SLOTS];
    int fill_level = 0;

    keeper_result_t expected_words [$];

    int items_sent = 0;
    int words_checked = 0;
    int mismatch_count = 0;
    int action_seen [8];
    int cycle_count = 0;
    int burst_left = 0;
    bit steady_sender = 1'b0;
    logic [7:0] rx_phase = '0;
    logic [1:0] rx_mode = '0;

    k_nearest_unique_keeper_core #(.SLOTS(SLOTS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("k_nearest_unique_keeper_core_tb failed");
            $finish;
        end
    end

    // receiver: modes change when the phase counter wraps, from always ready to long stalls
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_phase == 8'd0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= (rx_phase[3:0] < 4'd3);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // copy slot contents into a result word
    function automatic keeper_result_t with_entry(input keeper_result_t res, input int s);
        keeper_result_t r;
        r = res;
        r.valid = 1'b1;
        r.slot = SLOT_OUT_W'(s);
        r.entry_key = held_key[s];
        r.entry_seg = held_seg[s];
        r.entry_dist = held_dist[s];
        return r;
    endfunction

    // update the table for one word; returns 1 when a result word follows
    function automatic bit keep_table_step(input logic [OP_W-1:0] op,
                                           input logic [EDGE_W-1:0] key,
                                           input logic [SEG_W-1:0] seg,
                                           input logic [DIST_W-1:0] offer_dist,
                                           input logic [RSLOT_W-1:0] rslot,
                                           output keeper_result_t res);
        int s;
        int hit;
        int worst;
        res = '0;
        if (op == OP_CLEAR) begin
            // count drops to zero, contents stay but are never shown
            fill_level = 0;
            res.action = ACT_CLEARED;
            return 1'b1;
        end
        if (op == OP_READ) begin
            res.action = ACT_READ;
            res.slot = rslot;
            if (int'(rslot) < fill_level)
                res = with_entry(res, int'(rslot));
            res.fill = FILL_W'(fill_level);
            return 1'b1;
        end
        if (op != OP_OFFER)
            return 1'b0;

        hit = -1;
        for (s = 0; s < fill_level; s++)
            if (hit < 0 && held_key[s] == key)
                hit = s;

        if (hit >= 0) begin
            // held key: only a strictly smaller distance wins
            if (offer_dist < held_dist[hit]) begin
                held_seg[hit] = seg;
                held_dist[hit] = offer_dist;
                res.action = ACT_IMPROVED;
            end else begin
                res.action = ACT_KEPT;
            end
            s = hit;
        end else if (fill_level < SLOTS) begin
            s = fill_level;
            held_key[s] = key;
            held_seg[s] = seg;
            held_dist[s] = offer_dist;
            fill_level++;
            res.action = ACT_APPENDED;
        end else begin
            // worst: largest distance, then larger key
            worst = 0;
            for (s = 1; s < SLOTS; s++)
                if (held_dist[s] > held_dist[worst] ||
                    (held_dist[s] == held_dist[worst] && held_key[s] > held_key[worst]))
                    worst = s;
            if (offer_dist < held_dist[worst] ||
                (offer_dist == held_dist[worst] && key < held_key[worst])) begin
                held_key[worst] = key;
                held_seg[worst] = seg;
                held_dist[worst] = offer_dist;
                res.action = ACT_REPLACED;
            end else begin
                res.action = ACT_DROPPED;
            end
            s = worst;
        end
        res = with_entry(res, s);
        res.fill = FILL_W'(fill_level);
        return 1'b1;
    endfunction

    // send one word, with bursts and random gaps unless the sender is steady
    task automatic send_word(input logic [OP_W-1:0] op,
                             input logic [EDGE_W-1:0] key,
                             input logic [SEG_W-1:0] seg,
                             input logic [DIST_W-1:0] offer_dist,
                             input logic [RSLOT_W-1:0] rslot);
        keeper_result_t res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady_sender && $urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, rslot, offer_dist, seg, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op != OP_UNUSED)
            items_sent++;
        if (keep_table_step(op, key, seg, offer_dist, rslot, res))
            expected_words.insert(expected_words.size(), res);
    endtask

    // lower valid and let every expected word come back
    task automatic drain_results;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input keeper_result_t exp,
                                   input keeper_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t word %0d: %s", $realtime, words_checked, what);
            $display("  expected act=%0d vld=%0d slot=%0d key=%h seg=%h dist=%h fill=%0d pad=%h",
                     exp.action, exp.valid, exp.slot, exp.entry_key, exp.entry_seg,
                     exp.entry_dist, exp.fill, exp.pad);
            $display("  actual   act=%0d vld=%0d slot=%0d key=%h seg=%h dist=%h fill=%0d pad=%h",
                     got.action, got.valid, got.slot, got.entry_key, got.entry_seg,
                     got.entry_dist, got.fill, got.pad);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        keeper_result_t got;
        keeper_result_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            got.action = m_tuser[2:0];
            got.valid = m_tuser[3];
            got.slot = m_tdata[2:0];
            got.entry_key = m_tdata[18:3];
            got.entry_seg = m_tdata[38:19];
            got.entry_dist = m_tdata[62:39];
            got.fill = m_tdata[66:63];
            got.pad = m_tdata[71:67];
            words_checked++;
            action_seen[got.action]++;
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing expected", '0, got);
            end else begin
                exp = expected_words.pop_front();
                if (got !== exp)
                    report_mismatch("field mismatch", exp, got);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_empty_table;
        send_word(OP_CLEAR, 16'hFFFF, 20'hFFFFF, 24'hFFFFFF, 3'd7);
        send_word(OP_READ, 16'($urandom), 20'($urandom), 24'($urandom), 3'd0);
        send_word(OP_UNUSED, 16'($urandom), 20'($urandom), 24'($urandom), 3'($urandom));
        send_word(OP_READ, 16'($urandom), 20'($urandom), 24'($urandom), 3'd7);
    endtask

    task automatic test_append_and_hits;
        int i;
        // field extremes first, then keys 10..15
        send_word(OP_OFFER, 16'hFFFF, 20'hFFFFF, 24'hFFFFFF, 3'd7);
        send_word(OP_OFFER, 16'h0000, 20'h00000, 24'h000000, 3'd0);
        for (i = 0; i < SLOTS - 2; i++)
            send_word(OP_OFFER, 16'(10 + i), 20'($urandom), 24'(100 + 50 * (i / 2) * 2),
                      3'($urandom));
        // hit: smaller wins, equal and larger keep the held entry
        send_word(OP_OFFER, 16'd10, 20'h12345, 24'd50, 3'($urandom));
        send_word(OP_OFFER, 16'd10, 20'h54321, 24'd50, 3'($urandom));
        send_word(OP_OFFER, 16'd10, 20'h0ABCD, 24'd60, 3'($urandom));
        send_word(OP_READ, 16'($urandom), 20'($urandom), 24'($urandom), 3'd7);
        send_word(OP_UNUSED, 16'($urandom), 20'($urandom), 24'($urandom), 3'($urandom));
        send_word(OP_READ, 16'($urandom), 20'($urandom), 24'($urandom), 3'd2);
    endtask

    task automatic test_full_replacement;
        // new key better than worst, then far worse
        send_word(OP_OFFER, 16'd20, 20'($urandom), 24'd10, 3'($urandom));
        send_word(OP_OFFER, 16'd21, 20'($urandom), 24'hFFFFFF, 3'($urandom));
        // distance ties against the worst: smaller key wins, larger key drops
        send_word(OP_OFFER, 16'd5, 20'($urandom), 24'd300, 3'($urandom));
        send_word(OP_OFFER, 16'd40, 20'($urandom), 24'd300, 3'($urandom));
        send_word(OP_OFFER, 16'd1, 20'($urandom), 24'd300, 3'($urandom));
    endtask

    task automatic test_clear_hides_entries;
        send_word(OP_CLEAR, 16'($urandom), 20'($urandom), 24'($urandom), 3'($urandom));
        send_word(OP_READ, 16'($urandom), 20'($urandom), 24'($urandom), 3'd0);
        send_word(OP_OFFER, 16'hFFFF, 20'($urandom), 24'd0, 3'($urandom));
    endtask

    // well-formed offer sequences over small key pools
    task automatic test_random_sequences(input int target);
        logic [EDGE_W-1:0] key_pool [POOL_MAX];
        logic [DIST_W-1:0] offer_dist;
        int pool_size;
        int length;
        int dist_mode;
        int i;
        while (items_sent < target) begin
            steady_sender = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0)
                send_word(OP_CLEAR, 16'($urandom), 20'($urandom), 24'($urandom),
                          3'($urandom));
            pool_size = $urandom_range(4, POOL_MAX);
            for (i = 0; i < pool_size; i++) begin
                case ($urandom_range(0, 3))
                    0: key_pool[i] = 16'($urandom);
                    1: key_pool[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: key_pool[i] = 16'($urandom_range(0, 31));
                endcase
            end
            dist_mode = $urandom_range(0, 2);
            length = $urandom_range(8, 40);
            for (i = 0; i < length; i++) begin
                case (dist_mode)
                    0: offer_dist = 24'($urandom_range(0, 15));
                    1: offer_dist = 24'($urandom);
                    default: offer_dist = $urandom_range(0, 1) ? 24'($urandom_range(0, 3)) :
                                   ($urandom_range(0, 1) ? 24'hFFFFFF : 24'($urandom));
                endcase
                if ($urandom_range(0, 4) == 0)
                    send_word(OP_READ, 16'($urandom), 20'($urandom), 24'($urandom),
                              3'($urandom));
                else
                    send_word(OP_OFFER, key_pool[$urandom_range(0, pool_size - 1)],
                              20'($urandom), offer_dist, 3'($urandom));
            end
        end
        steady_sender = 1'b0;
    endtask

    // arbitrary words, including the unused operation
    task automatic test_noise(input int target);
        while (items_sent < target)
            send_word(2'($urandom), 16'($urandom), 20'($urandom), 24'($urandom),
                      3'($urandom));
    endtask

    initial begin
        int i;
        for (i = 0; i < SLOTS; i++) begin
            held_key[i] = '0;
            held_seg[i] = '0;
            held_dist[i] = '0;
        end
        for (i = 0; i < 8; i++)
            action_seen[i] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_append_and_hits();
        test_full_replacement();
        test_clear_hides_entries();
        // hold the sender until the core is empty
        drain_results();
        test_random_sequences(items_sent + RANDOM_ITEMS * 3 / 5);
        test_noise(items_sent + RANDOM_ITEMS / 10);
        drain_results();
        test_random_sequences(items_sent + RANDOM_ITEMS * 3 / 10);

        drain_results();
        repeat (SLOTS + 20) @(posedge aclk);

        $display("%0d words sent, %0d results checked, %0d mismatches",
                 items_sent, words_checked, mismatch_count);
        $display("actions: clr %0d, impr %0d, kept %0d, app %0d, repl %0d, drop %0d, read %0d",
                 action_seen[ACT_CLEARED], action_seen[ACT_IMPROVED], action_seen[ACT_KEPT],
                 action_seen[ACT_APPENDED], action_seen[ACT_REPLACED],
                 action_seen[ACT_DROPPED], action_seen[ACT_READ]);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("k_nearest_unique_keeper_core_tb passed");
        else
            $display("k_nearest_unique_keeper_core_tb failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/knuk_pkg.sv
sv/knuk_ctrl.sv
sv/knuk_dpath.sv
sv/k_nearest_unique_keeper_core.sv
test/k_nearest_unique_keeper_core_tb.sv
